// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker of this block.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/edvc_pkg.sv -----
// Shared types and fixed constants of the edge delta varint chunker.
// Depends on nothing; used by the top level and its checker.
package edvc_pkg;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_GAP    = 2'd1,
      KIND_FREE   = 2'd2,
      KIND_FLUSH  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REC_OPEN  = 2'd0,
      REC_EDGE  = 2'd1,
      REC_CLOSE = 2'd2
   } rec_type;

   localparam int HDR_BYTES    = 14;
   localparam int VARINT_SLACK = 10;
   localparam int MAX_VARINT   = 8;

endpackage

// ----- src/edge_delta_varint_chunker.sv -----
// Top level of the edge delta varint chunker: sample front end, work stage
// and result register. Depends on edvc_pkg.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid, req_stall | kind, levels, gap_halves
//   rsp_     | out       | rsp_valid, rsp_stall | record_kind .. last
//
// An item with no record does not hold the work stage, and such items are
// accepted back to back. A sample item holds the work stage for its records,
// since the edge encoder emits one record a cycle when the result register is
// free, and while edges are dropped after its last record. Synchronous reset
// clears all chunk state and sets a pending resync. A stalled result waits in
// the result register while the work stage fills behind it.
module edge_delta_varint_chunker #(
   parameter int HALF_SAMPLES = 4096,
   parameter int CHUNK_BYTES  = 512,
   parameter int CHUNK_SLOTS  = 8,
   parameter int INDEX_WIDTH  = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  edvc_pkg::kind_type req_kind,
   input  logic [7:0]         req_levels,
   input  logic [15:0]        req_gap_halves,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output edvc_pkg::rec_type  rsp_record_kind,
   output logic [2:0]         rsp_slot,
   output logic [8:0]         rsp_offset,
   output logic [63:0]        rsp_data,
   output logic [3:0]         rsp_byte_count,
   output logic [7:0]         rsp_sequence_res,
   output logic [8:0]         rsp_payload_length,
   output logic [15:0]        rsp_lost,
   output logic               rsp_last
);
   import edvc_pkg::*;

   localparam int IW     = INDEX_WIDTH;
   localparam int FILL_W = $clog2(CHUNK_BYTES);
   localparam int SLOT_W = $clog2(CHUNK_SLOTS);
   localparam int CNT_W  = $clog2(CHUNK_SLOTS + 1);
   localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(CHUNK_BYTES - VARINT_SLACK);
   localparam logic [FILL_W-1:0] FILL_HDR   = FILL_W'(HDR_BYTES);
   localparam logic [CNT_W-1:0]  SLOTS_ALL  = CNT_W'(CHUNK_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(CHUNK_SLOTS - 1);
   localparam logic [16:0]       HALF_C     = 17'(HALF_SAMPLES);

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [16:0] b);
      logic [17:0] s;
      s = {2'b00, a} + {1'b0, b};
      sat_add = (s > 18'h0FFFF) ? 16'hFFFF : s[15:0];
   endfunction

   // Sample front end.
   logic [IW-1:0] sample_index_ff, sample_index_in;
   logic [7:0]    prev_levels_ff, prev_levels_in;
   logic          resync_ff, resync_in;
   logic [32:0]   gap_advance;
   logic          req_acc;

   // Work stage.
   logic          w_vld_ff;
   kind_type      w_kind_ff;
   logic [7:0]    w_levels_ff;
   logic [7:0]    w_mask_ff, w_mask_in;
   logic [IW-1:0] w_idx_ff;
   logic [15:0]   w_halves_ff;
   logic          w_close_ff, w_close_in;

   // Chunk state.
   logic [IW-1:0]     last_edge_ff, last_edge_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              open_ff, open_in;
   logic [SLOT_W-1:0] fill_slot_ff, fill_slot_in;
   logic [CNT_W-1:0]  slots_ff, slots_in;
   logic [7:0]        seq_ff, seq_in;
   logic [15:0]       lost_ff, lost_in;

   // Edge encoder.
   logic [7:0]        low_bit;
   logic [2:0]        ch_sel;
   logic              level_sel;
   logic [IW-1:0]     delta;
   logic [55:0]       value;
   logic [8:0]        nz;
   logic [3:0]        count;
   logic [63:0]       varint;
   logic [FILL_W-1:0] fill_edge;

   // Step control and result register.
   logic        emit, done, out_free, rec_last;
   rec_type     rec_kind;
   logic [2:0]  rec_slot;
   logic [8:0]  rec_offset;
   logic [63:0] rec_data;
   logic [3:0]  rec_count;
   logic [7:0]  rec_seq;
   logic [8:0]  rec_payload;
   logic [15:0] rec_lost;

   logic        o_vld_ff;
   rec_type     o_kind_ff;
   logic [2:0]  o_slot_ff;
   logic [8:0]  o_offset_ff;
   logic [63:0] o_data_ff;
   logic [3:0]  o_count_ff;
   logic [7:0]  o_seq_ff;
   logic [8:0]  o_payload_ff;
   logic [15:0] o_lost_ff;
   logic        o_last_ff;

   assign out_free  = !o_vld_ff || !rsp_stall;
   assign req_stall = w_vld_ff && !done;
   assign req_acc   = req_valid && !req_stall;

   assign gap_advance = 33'(req_gap_halves) * 33'(HALF_C);

   always_comb begin
      sample_index_in = sample_index_ff;
      prev_levels_in  = prev_levels_ff;
      resync_in       = resync_ff;
      if (req_acc) begin
         unique case (req_kind)
            KIND_SAMPLE: begin
               sample_index_in = sample_index_ff + IW'(1);
               prev_levels_in  = req_levels;
               resync_in       = 1'b0;
            end
            KIND_GAP: begin
               sample_index_in = sample_index_ff + IW'(gap_advance);
               resync_in       = 1'b1;
            end
            KIND_FREE, KIND_FLUSH: begin
               resync_in = resync_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         prev_levels_ff  <= '0;
         resync_ff       <= 1'b1;
      end else begin
         sample_index_ff <= sample_index_in;
         prev_levels_ff  <= prev_levels_in;
         resync_ff       <= resync_in;
      end
   end

   // The lowest changed channel is encoded first.
   always_comb begin
      low_bit   = w_mask_ff & (~w_mask_ff + 8'd1);
      ch_sel    = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (w_mask_ff[i]) begin
            ch_sel = 3'(i);
         end
      end
      level_sel = |(w_levels_ff & low_bit);
      delta     = w_idx_ff - last_edge_ff;
      value     = 56'({delta, level_sel, ch_sel});
      nz[0]     = 1'b1;
      nz[8]     = 1'b0;
      for (int k = 1; k < 8; k++) begin
         nz[k] = (value >> (7 * k)) != 56'd0;
      end
      count = 4'd1 + 4'($countones(nz[7:1]));
      for (int k = 0; k < 8; k++) begin
         varint[8*k +: 8] = nz[k] ? {nz[k+1], value[7*k +: 7]} : 8'd0;
      end
      fill_edge = fill_ff + FILL_W'(count);
   end

   always_comb begin
      last_edge_in = last_edge_ff;
      fill_in      = fill_ff;
      open_in      = open_ff;
      fill_slot_in = fill_slot_ff;
      slots_in     = slots_ff;
      seq_in       = seq_ff;
      lost_in      = lost_ff;
      w_mask_in    = w_mask_ff;
      w_close_in   = w_close_ff;
      emit         = 1'b0;
      done         = 1'b0;
      rec_last     = 1'b0;
      rec_kind     = REC_CLOSE;
      rec_slot     = 3'(fill_slot_ff);
      rec_offset   = 9'd0;
      rec_data     = 64'd0;
      rec_count    = 4'd0;
      rec_seq      = seq_ff;
      rec_payload  = 9'(fill_ff - FILL_HDR);
      rec_lost     = lost_ff;

      if (w_vld_ff) begin
         unique case (w_kind_ff)
            KIND_GAP: begin
               lost_in = sat_add(lost_ff, 17'(w_halves_ff));
               done    = 1'b1;
            end
            KIND_FREE: begin
               if (slots_ff != '0) begin
                  slots_in = slots_ff - CNT_W'(1);
               end
               done = 1'b1;
            end
            KIND_FLUSH: begin
               done = 1'b1;
               if (open_ff && fill_ff > FILL_HDR) begin
                  emit     = 1'b1;
                  rec_last = 1'b1;
               end
            end
            KIND_SAMPLE: begin
               priority if (w_close_ff) begin
                  emit       = 1'b1;
                  w_close_in = 1'b0;
                  done       = w_mask_ff == 8'd0;
                  rec_last   = done || (slots_ff + CNT_W'(1) >= SLOTS_ALL);
               end else if (w_mask_ff == 8'd0) begin
                  done = 1'b1;
               end else if (!open_ff && slots_ff >= SLOTS_ALL) begin
                  lost_in   = sat_add(lost_ff, 17'($countones(w_mask_ff)));
                  w_mask_in = 8'd0;
                  done      = 1'b1;
               end else if (!open_ff) begin
                  emit     = 1'b1;
                  rec_kind = REC_OPEN;
                  rec_data = 64'(last_edge_ff);
                  rec_seq  = 8'd0;
                  rec_payload = 9'd0;
                  rec_lost = 16'd0;
                  open_in  = 1'b1;
                  fill_in  = FILL_HDR;
               end else begin
                  emit         = 1'b1;
                  rec_kind     = REC_EDGE;
                  rec_offset   = 9'(fill_ff);
                  rec_data     = varint;
                  rec_count    = count;
                  rec_seq      = 8'd0;
                  rec_payload  = 9'd0;
                  rec_lost     = 16'd0;
                  fill_in      = fill_edge;
                  last_edge_in = w_idx_ff;
                  w_mask_in    = w_mask_ff & ~low_bit;
                  w_close_in   = fill_edge > FILL_LIMIT;
                  rec_last     = !w_close_in && w_mask_in == 8'd0;
                  done         = rec_last;
               end
            end
         endcase

         if (emit && rec_kind == REC_CLOSE) begin
            seq_in       = seq_ff + 8'd1;
            lost_in      = 16'd0;
            fill_slot_in = (fill_slot_ff == SLOT_LAST) ? '0 : fill_slot_ff + SLOT_W'(1);
            slots_in     = slots_ff + CNT_W'(1);
            open_in      = 1'b0;
            fill_in      = '0;
         end

         if (emit && !out_free) begin
            last_edge_in = last_edge_ff;
            fill_in      = fill_ff;
            open_in      = open_ff;
            fill_slot_in = fill_slot_ff;
            slots_in     = slots_ff;
            seq_in       = seq_ff;
            lost_in      = lost_ff;
            w_mask_in    = w_mask_ff;
            w_close_in   = w_close_ff;
            done         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff   <= 1'b0;
         w_close_ff <= 1'b0;
      end else if (req_acc) begin
         w_vld_ff   <= 1'b1;
         w_close_ff <= 1'b0;
      end else begin
         w_vld_ff   <= w_vld_ff && !done;
         w_close_ff <= w_close_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         w_kind_ff   <= req_kind;
         w_levels_ff <= req_levels;
         w_mask_ff   <= resync_ff ? 8'd0 : (req_levels ^ prev_levels_ff);
         w_idx_ff    <= sample_index_ff;
         w_halves_ff <= req_gap_halves;
      end else begin
         w_mask_ff <= w_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         fill_ff      <= '0;
         open_ff      <= 1'b0;
         fill_slot_ff <= '0;
         slots_ff     <= '0;
         seq_ff       <= '0;
         lost_ff      <= '0;
      end else begin
         last_edge_ff <= last_edge_in;
         fill_ff      <= fill_in;
         open_ff      <= open_in;
         fill_slot_ff <= fill_slot_in;
         slots_ff     <= slots_in;
         seq_ff       <= seq_in;
         lost_ff      <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (emit && out_free) begin
         o_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         o_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && out_free) begin
         o_kind_ff    <= rec_kind;
         o_slot_ff    <= rec_slot;
         o_offset_ff  <= rec_offset;
         o_data_ff    <= rec_data;
         o_count_ff   <= rec_count;
         o_seq_ff     <= rec_seq;
         o_payload_ff <= rec_payload;
         o_lost_ff    <= rec_lost;
         o_last_ff    <= rec_last;
      end
   end

   assign rsp_valid          = o_vld_ff;
   assign rsp_record_kind    = o_kind_ff;
   assign rsp_slot           = o_slot_ff;
   assign rsp_offset         = o_offset_ff;
   assign rsp_data           = o_data_ff;
   assign rsp_byte_count     = o_count_ff;
   assign rsp_sequence_res   = o_seq_ff;
   assign rsp_payload_length = o_payload_ff;
   assign rsp_lost           = o_lost_ff;
   assign rsp_last           = o_last_ff;

endmodule

// ----- src/edvc_checker.sv -----
// Port-level checker for the edge delta varint chunker and its bind.
// Depends on edvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module edvc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input edvc_pkg::rec_type rsp_record_kind,
   input logic [3:0]        rsp_byte_count,
   input logic              rsp_last
);
   import edvc_pkg::*;

   // A stalled transaction stays offered.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped while stalled")

   // An open record is never marked last, since its edge record always follows.
   `ASSERT_CLK(a_open_not_last, clock, reset, rsp_valid && rsp_record_kind == REC_OPEN |-> !rsp_last, "open record marked last")

   `ASSERT_CLK(a_edge_count, clock, reset, rsp_valid && rsp_record_kind == REC_EDGE |-> rsp_byte_count >= 4'd1 && rsp_byte_count <= 4'(MAX_VARINT), "edge byte count out of range")

   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result offered right after reset")

endmodule

bind edge_delta_varint_chunker edvc_checker u_edvc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_record_kind (rsp_record_kind),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_last        (rsp_last)
);

// ----- bench/edvc_record_checker.sv -----
// Checker for the edge delta varint chunker: predicts the records of every accepted input
// transaction and compares each result transaction, field by field, in order.
// Depends on edvc_pkg.
`timescale 1ns / 1ps

module edvc_record_checker
   import edvc_pkg::*;
#(
   parameter int HALF_SAMPLES = 4096,
   parameter int CHUNK_BYTES  = 512,
   parameter int CHUNK_SLOTS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  kind_type    req_kind,
   input  logic [7:0]  req_levels,
   input  logic [15:0] req_gap_halves,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rec_type     rsp_record_kind,
   input  logic [2:0]  rsp_slot,
   input  logic [8:0]  rsp_offset,
   input  logic [63:0] rsp_data,
   input  logic [3:0]  rsp_byte_count,
   input  logic [7:0]  rsp_sequence_res,
   input  logic [8:0]  rsp_payload_length,
   input  logic [15:0] rsp_lost,
   input  logic        rsp_last,
   output int          failures,
   output int          records_pending
);

   typedef struct packed {
      rec_type     kind;
      logic [2:0]  slot;
      logic [8:0]  offset;
      logic [63:0] data;
      logic [3:0]  byte_count;
      logic [7:0]  sequence_res;
      logic [8:0]  payload_length;
      logic [15:0] lost;
      logic        last;
   } chunk_record_t;

   logic [47:0] smp_index;
   logic [47:0] edge_base;
   logic [7:0]  held_levels;
   logic        resync;
   logic [9:0]  fill_bytes;
   logic        have_chunk;
   logic [2:0]  fill_slot;
   logic [3:0]  slots_used;
   logic [7:0]  seq_count;
   logic [15:0] lost_count;
   int          mismatch_count = 0;
   chunk_record_t records_due[$];
   chunk_record_t seen;
   chunk_record_t want;

   function automatic chunk_record_t make_record(rec_type k, logic [2:0] s, logic [8:0] off,
                                                 logic [63:0] d, logic [3:0] bc,
                                                 logic [7:0] sq, logic [8:0] pl,
                                                 logic [15:0] ls);
      chunk_record_t r;
      r.kind = k;
      r.slot = s;
      r.offset = off;
      r.data = d;
      r.byte_count = bc;
      r.sequence_res = sq;
      r.payload_length = pl;
      r.lost = ls;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void add_lost(logic [15:0] amount);
      logic [16:0] sum;
      sum = {1'b0, lost_count} + {1'b0, amount};
      lost_count = sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   function automatic void close_chunk();
      logic [9:0] payload;
      payload = fill_bytes - 10'(HDR_BYTES);
      records_due.push_back(make_record(REC_CLOSE, fill_slot, '0, '0, '0, seq_count,
                                        payload[8:0], lost_count));
      seq_count = seq_count + 8'd1;
      lost_count = '0;
      fill_slot = 3'((int'(fill_slot) + 1) % CHUNK_SLOTS);
      slots_used = slots_used + 4'd1;
      have_chunk = 1'b0;
      fill_bytes = '0;
   endfunction

   function automatic void encode_edge(logic [47:0] idx, int ch, logic level);
      logic [63:0] v;
      logic [63:0] packed_bytes;
      logic [6:0]  low7;
      logic [9:0]  start;
      int          count;
      if (!have_chunk) begin
         if (int'(slots_used) >= CHUNK_SLOTS) begin
            add_lost(16'd1);
            return;
         end
         records_due.push_back(make_record(REC_OPEN, fill_slot, '0, {16'b0, edge_base},
                                           '0, '0, '0, '0));
         have_chunk = 1'b1;
         fill_bytes = 10'(HDR_BYTES);
      end
      v = {12'b0, idx - edge_base, level, 3'(ch)};
      edge_base = idx;
      start = fill_bytes;
      packed_bytes = '0;
      count = 0;
      do begin
         low7 = v[6:0];
         v = v >> 7;
         packed_bytes[8*count +: 8] = {v != 0, low7};
         count++;
      end while (v != 0 && count < MAX_VARINT);
      fill_bytes = fill_bytes + 10'(count);
      records_due.push_back(make_record(REC_EDGE, fill_slot, start[8:0], packed_bytes,
                                        4'(count), '0, '0, '0));
      if (int'(fill_bytes) > CHUNK_BYTES - VARINT_SLACK)
         close_chunk();
   endfunction

   function automatic void predict_records(kind_type k, logic [7:0] lv, logic [15:0] halves);
      int          queued_at_start;
      int          ch;
      logic [7:0]  diff;
      logic [47:0] idx;
      queued_at_start = records_due.size();
      case (k)
         KIND_SAMPLE: begin
            idx = smp_index;
            smp_index = smp_index + 48'd1;
            if (resync) begin
               held_levels = lv;
               resync = 1'b0;
            end else begin
               diff = lv ^ held_levels;
               for (ch = 0; ch < 8; ch++)
                  if (diff[ch])
                     encode_edge(idx, ch, lv[ch]);
               held_levels = lv;
            end
         end
         KIND_GAP: begin
            smp_index = smp_index + {32'b0, halves} * 48'(HALF_SAMPLES);
            add_lost(halves);
            resync = 1'b1;
         end
         KIND_FREE: begin
            if (slots_used > 0)
               slots_used = slots_used - 4'd1;
         end
         default: begin
            if (have_chunk && int'(fill_bytes) > HDR_BYTES)
               close_chunk();
         end
      endcase
      if (records_due.size() > queued_at_start)
         records_due[records_due.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         smp_index = '0;
         edge_base = '0;
         held_levels = '0;
         resync = 1'b1;
         fill_bytes = '0;
         have_chunk = 1'b0;
         fill_slot = '0;
         slots_used = '0;
         seq_count = '0;
         lost_count = '0;
         records_due.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_records(req_kind, req_levels, req_gap_halves);
         if (rsp_valid && !rsp_stall) begin
            seen = make_record(rsp_record_kind, rsp_slot, rsp_offset, rsp_data,
                               rsp_byte_count, rsp_sequence_res, rsp_payload_length, rsp_lost);
            seen.last = rsp_last;
            if (records_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: result transaction with none expected, expected none, actual %p",
                        $time, seen);
            end else begin
               want = records_due.pop_front();
               check_field("record_kind", want.kind, seen.kind);
               check_field("slot", want.slot, seen.slot);
               check_field("offset", want.offset, seen.offset);
               check_field("data", want.data, seen.data);
               check_field("byte_count", want.byte_count, seen.byte_count);
               check_field("sequence_res", want.sequence_res, seen.sequence_res);
               check_field("payload_length", want.payload_length, seen.payload_length);
               check_field("lost", want.lost, seen.lost);
               check_field("last", want.last, seen.last);
            end
         end
      end
      failures <= mismatch_count;
      records_pending <= records_due.size();
   end

endmodule

// ----- bench/tb_edge_delta_varint_chunker.sv -----
// Testbench top for the edge delta varint chunker: drives directed and random input
// transactions with changing idle patterns and gives the verdict.
// Depends on edvc_pkg, edge_delta_varint_chunker and edvc_record_checker.
`timescale 1ns / 1ps

module tb_edge_delta_varint_chunker;
   import edvc_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   kind_type    req_kind = KIND_SAMPLE;
   logic [7:0]  req_levels = '0;
   logic [15:0] req_gap_halves = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rec_type     rsp_record_kind;
   logic [2:0]  rsp_slot;
   logic [8:0]  rsp_offset;
   logic [63:0] rsp_data;
   logic [3:0]  rsp_byte_count;
   logic [7:0]  rsp_sequence_res;
   logic [8:0]  rsp_payload_length;
   logic [15:0] rsp_lost;
   logic        rsp_last;

   int          failures;
   int          records_pending;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          results_taken = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic        long_hold_done = 1'b0;
   logic [7:0]  last_levels = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   edge_delta_varint_chunker DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_levels         (req_levels),
      .req_gap_halves     (req_gap_halves),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_slot           (rsp_slot),
      .rsp_offset         (rsp_offset),
      .rsp_data           (rsp_data),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_lost           (rsp_lost),
      .rsp_last           (rsp_last)
   );

   edvc_record_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_levels         (req_levels),
      .req_gap_halves     (req_gap_halves),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_slot           (rsp_slot),
      .rsp_offset         (rsp_offset),
      .rsp_data           (rsp_data),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_lost           (rsp_lost),
      .rsp_last           (rsp_last),
      .failures           (failures),
      .records_pending    (records_pending)
   );

   // The receiver holds off once for a long stretch so that the block fills and
   // stalls its input while the sender keeps offering transactions.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         results_taken++;
      if (!long_hold_done && results_taken >= 60) begin
         hold_left = HOLD_CYCLES;
         long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_item(input kind_type k, input logic [7:0] lv, input logic [15:0] halves);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_levels <= lv;
      req_gap_halves <= halves;
      if (k == KIND_SAMPLE)
         last_levels = lv;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_items(input int count);
      int          pick;
      logic [7:0]  lv;
      logic [15:0] halves;
      repeat (count) begin
         pick = $urandom_range(99);
         lv = 8'($urandom);
         halves = 16'($urandom);
         if (pick < 72) begin
            pick = $urandom_range(99);
            if (pick < 45)
               lv = ~last_levels;
            else if (pick >= 75)
               lv = last_levels ^ (8'd1 << $urandom_range(7));
            send_item(KIND_SAMPLE, lv, halves);
         end else if (pick < 80) begin
            pick = $urandom_range(99);
            if (pick < 40)
               halves = 16'($urandom_range(3));
            else if (pick >= 80)
               halves = 16'hFFFF;
            send_item(KIND_GAP, lv, halves);
         end else if (pick < 94) begin
            send_item(KIND_FREE, lv, halves);
         end else begin
            send_item(KIND_FLUSH, lv, halves);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 30;
      recv_idle_pct = 81;

      // Free and flush with nothing in use, then a resync sample, a full toggle and a partial one.
      send_item(KIND_FREE, 8'h00, 16'h0000);
      send_item(KIND_FLUSH, 8'h00, 16'h0000);
      send_item(KIND_SAMPLE, 8'hFF, 16'h0000);
      send_item(KIND_SAMPLE, 8'h00, 16'hFFFF);
      send_item(KIND_SAMPLE, 8'hA5, 16'h0000);
      send_item(KIND_FLUSH, 8'hFF, 16'h0000);
      send_item(KIND_FLUSH, 8'h00, 16'h0000);
      // A maximal gap saturates the lost count and forces a long delta.
      send_item(KIND_GAP, 8'hFF, 16'hFFFF);
      send_item(KIND_SAMPLE, 8'h5A, 16'h0000);
      send_item(KIND_SAMPLE, 8'hA5, 16'h0000);
      send_item(KIND_FLUSH, 8'h00, 16'h0000);
      send_item(KIND_GAP, 8'h00, 16'h0000);
      send_item(KIND_SAMPLE, 8'h01, 16'h0000);
      send_item(KIND_SAMPLE, 8'h00, 16'h0000);
      send_item(KIND_FLUSH, 8'h00, 16'h0000);
      // Fill every slot, then both edges of the next sample are dropped.
      repeat (5) begin
         send_item(KIND_SAMPLE, last_levels ^ 8'h80, 16'h0000);
         send_item(KIND_FLUSH, 8'h00, 16'h0000);
      end
      send_item(KIND_SAMPLE, last_levels ^ 8'h42, 16'h0000);

      random_items(48);
      send_idle_pct = 81;
      recv_idle_pct = 30;
      random_items(48);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_items(48);

      req_valid <= 1'b0;
      @(posedge clock);
      while (records_pending != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/edvc_pkg.sv
src/edge_delta_varint_chunker.sv
src/edvc_checker.sv
bench/edvc_record_checker.sv
bench/tb_edge_delta_varint_chunker.sv
